>>> rtl/core/sha1_bsh_pkg.sv
package sha1_bsh_pkg;

    // Round constants, one per group of twenty rounds
    parameter logic [31:0] K_R0 = 32'h5A827999;
    parameter logic [31:0] K_R1 = 32'h6ED9EBA1;
    parameter logic [31:0] K_R2 = 32'h8F1BBCDC;
    parameter logic [31:0] K_R3 = 32'hCA62C1D6;

    // Initial chaining value H0..H4
    parameter logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Padding marker byte and byte position where the length field starts
    parameter logic [7:0] PAD_MARK = 8'h80;
    parameter logic [5:0] LEN_POS  = 6'd56;

    // Input command codes
    parameter logic CMD_ABSORB = 1'b0;
    parameter logic CMD_FINISH = 1'b1;

    // Last round index and last digest word index
    parameter logic [6:0] LAST_ROUND = 7'd79;
    parameter logic [2:0] LAST_WORD  = 3'd4;

endpackage

>>> rtl/core/sha1_byte_stream_hasher.sv
// Channel  Dir  tdata                     tuser / tlast
// s_*      in   [7:0] message_byte        tuser: command (0 absorb, 1 finish)
// m_*      out  [31:0] digest_word        tlast: last_word
//
// An absorb request shifts one byte into the block; the 64th byte of a block
// starts compression (the rounds through the single round unit, then one chaining add).
// A finish request feeds padding and length bytes at one a cycle up to the end
// of the block (plus one more block when 56 or more bytes are pending), compressing
// each block in turn, then shows the five digest words one a cycle while m_tready is high.
// s_tready is high only while idle. A stalled m_tready holds the current word.
// Reset (rst_n low, asynchronous) loads the initial chaining value and clears
// the length; the block buffer is not cleared.
module sha1_byte_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast    // last_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [5:0]   pos_reg, pos_next;
    logic [63:0]  len_reg, len_next;
    logic         fin_reg, fin_next;
    logic         spill_reg, spill_next;
    logic         last_reg, last_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic [2:0]   widx_reg, widx_next;
    logic [31:0]  h_reg [5];
    logic [31:0]  h_next [5];
    logic [511:0] win_reg, win_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;

    logic         byte_wr;
    logic [7:0]   byte_val;
    logic         spill_eff;
    logic [7:0]   pad_byte;
    logic [31:0]  w0, w2, w8, w13, sched_x, sched_new;
    logic [31:0]  f_val, k_val, round_sum;

    // Schedule taps: window holds w[t] .. w[t+15], oldest in the top word
    assign w0  = win_reg[511 -: 32];
    assign w2  = win_reg[511 - 64 -: 32];
    assign w8  = win_reg[511 - 256 -: 32];
    assign w13 = win_reg[511 - 416 -: 32];
    assign sched_x   = w13 ^ w8 ^ w2 ^ w0;
    assign sched_new = {sched_x[30:0], sched_x[31]};

    // Round function and constant by round group
    always_comb
    begin
        priority if (rnd_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_bsh_pkg::K_R0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_bsh_pkg::K_R1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_bsh_pkg::K_R2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_bsh_pkg::K_R3;
        end
    end

    assign round_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;

    // Padding byte: length bytes big-endian in the last eight positions
    assign pad_byte = (pos_reg >= sha1_bsh_pkg::LEN_POS && !spill_reg)
                    ? 8'(len_reg >> {~pos_reg[2:0], 3'b000}) : 8'h00;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = h_reg[widx_reg];
    assign m_tlast  = (widx_reg == sha1_bsh_pkg::LAST_WORD);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        fin_next   = fin_reg;
        spill_next = spill_reg;
        last_next  = last_reg;
        rnd_next   = rnd_reg;
        widx_next  = widx_reg;
        h_next     = h_reg;
        win_next   = win_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        byte_wr    = 1'b0;
        byte_val   = 8'h00;
        spill_eff  = spill_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_wr = 1'b1;
                    if (s_tuser == sha1_bsh_pkg::CMD_ABSORB)
                    begin
                        byte_val = s_tdata;
                        len_next = len_reg + 64'd8;
                    end
                    else
                    begin
                        byte_val  = sha1_bsh_pkg::PAD_MARK;
                        fin_next  = 1'b1;
                        spill_eff = (pos_reg >= sha1_bsh_pkg::LEN_POS);
                    end
                end
            end
            S_PAD:
            begin
                byte_wr  = 1'b1;
                byte_val = pad_byte;
            end
            S_ROUND:
            begin
                // Advance one round and slide the schedule window
                win_next = {win_reg[479:0], sched_new};
                e_next   = d_reg;
                d_next   = c_reg;
                c_next   = {b_reg[1:0], b_reg[31:2]};
                b_next   = a_reg;
                a_next   = round_sum;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == sha1_bsh_pkg::LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                if (!fin_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (last_reg)
                begin
                    state_next = S_OUT;
                    widx_next  = 3'd0;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == sha1_bsh_pkg::LAST_WORD)
                    begin
                        // Return to the initial state for the next message
                        state_next = S_IDLE;
                        h_next     = sha1_bsh_pkg::H_INIT;
                        len_next   = 64'd0;
                        pos_next   = 6'd0;
                        fin_next   = 1'b0;
                        spill_next = 1'b0;
                        last_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Shift a byte into the block and start compression on a full block
        if (byte_wr)
        begin
            win_next = {win_reg[503:0], byte_val};
            pos_next = pos_reg + 6'd1;
            if (pos_reg == 6'd63)
            begin
                state_next = S_ROUND;
                rnd_next   = 7'd0;
                a_next     = h_reg[0];
                b_next     = h_reg[1];
                c_next     = h_reg[2];
                d_next     = h_reg[3];
                e_next     = h_reg[4];
                last_next  = fin_next && !spill_eff;
                spill_next = 1'b0;
            end
            else
            begin
                state_next = fin_next ? S_PAD : S_IDLE;
                spill_next = fin_next && spill_eff;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= 6'd0;
            len_reg   <= 64'd0;
            fin_reg   <= 1'b0;
            spill_reg <= 1'b0;
            last_reg  <= 1'b0;
            rnd_reg   <= 7'd0;
            widx_reg  <= 3'd0;
            h_reg     <= sha1_bsh_pkg::H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            fin_reg   <= fin_next;
            spill_reg <= spill_next;
            last_reg  <= last_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
            h_reg     <= h_next;
        end
    end

    // Block window and working variables
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

endmodule
